[rtl/core/ovl_pkg.sv]
// shared types and constants of the ordered value list engine
package ovl_pkg;

   // width of one list entry and of the reported occupancy
   localparam int unsigned DATA_W = 32;
   localparam int unsigned OCC_W  = 5;

   // operation codes carried in a request word
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_SEARCH = 2'd1,
      OP_UPDATE = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   // status codes carried in a response word
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic                     fire;
      op_type                   op;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] new_value;
   } ctl_type;

endpackage

[rtl/core/ovl_if.sv]
// request and response channel interfaces of the ordered value list engine
interface ovl_req_if
   import ovl_pkg::*;
();
   logic                     valid;
   logic                     ready;
   op_type                   operation;
   logic signed [DATA_W-1:0] value;
   logic signed [DATA_W-1:0] new_value;

   modport source (output valid, output operation, output value, output new_value,
                   input ready);
   modport sink   (input valid, input operation, input value, input new_value,
                   output ready);
endinterface

interface ovl_rsp_if
   import ovl_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             found;
   status_type       status;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, output found, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input found, input status, input occupancy,
                   output ready);
endinterface

[rtl/core/ordered_value_list_engine.sv]
// ordered value list engine: a row of slots holding a list, oldest first
//
// A request word carries an operation, a value and a replacement value:
// append adds the value at the tail (status full when no slot is free),
// search reports whether the value is held, update replaces the first match
// from the head, delete removes the first match and the later entries move
// one slot toward the head. Every request gives exactly one response word
// with found, status and the occupancy after the operation.
// All slots compare against the value in parallel and a one-bit chain from
// the head picks the first match, so one request completes per cycle while
// the response side does not stall; the response appears in the output
// register in the cycle after the request is taken.
// A stalled response holds in the output register; req_chan.ready then stays
// low until the response is taken, or rises in the cycle it is taken.
// Reset clears the fill count and the response valid; slot contents are
// left as they are and are never read before they are written.
module ordered_value_list_engine
   import ovl_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic   clock,
   input  logic   reset,
   ovl_req_if.sink   req_chan,
   ovl_rsp_if.source rsp_chan
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ctl_type                  ctl;
   logic                     accept;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic signed [DATA_W-1:0] entry [DEPTH];
   logic [DEPTH:0]           seen;
   logic                     found_any;
   logic                     full;
   logic                     res_found;
   status_type               res_status;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_found_ff;
   status_type               rsp_status_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;

   // request handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // control broadcast to the slot row
   assign ctl.fire      = accept;
   assign ctl.op        = req_chan.operation;
   assign ctl.value     = req_chan.value;
   assign ctl.new_value = req_chan.new_value;

   // slot row
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] right_entry;
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_mid
         assign right_entry = entry[i+1];
      end
      ovl_cell #(
         .INDEX(i),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .right_entry(right_entry),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .entry      (entry[i])
      );
   end

   assign found_any = seen[DEPTH];
   assign full      = count_ff == CNT_W'(DEPTH);

   // result and next fill count
   always_comb begin
      res_found  = 1'b0;
      res_status = ST_OK;
      count_in   = count_ff;
      case (req_chan.operation)
         OP_APPEND: begin
            if (full) res_status = ST_FULL;
            else      count_in   = count_ff + CNT_W'(1);
         end
         OP_SEARCH, OP_UPDATE: begin
            res_found = found_any;
            if (!found_any) res_status = ST_NOT_FOUND;
         end
         OP_DELETE: begin
            if (count_ff == '0) begin
               res_status = ST_EMPTY;
            end else if (found_any) begin
               res_found = 1'b1;
               count_in  = count_ff - CNT_W'(1);
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
         default: begin
            res_status = ST_OK;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   // fill count and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_found_ff  <= res_found;
         rsp_status_ff <= res_status;
         rsp_occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.occupancy = rsp_occ_ff;

endmodule

[rtl/core/ovl_cell.sv]
// one list slot: holds an entry, compares it and shifts from its right neighbor
module ovl_cell
   import ovl_pkg::*;
#(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 5
) (
   input  logic                     clock,
   input  ctl_type                  ctl,
   input  logic [CNT_W-1:0]         count,
   input  logic signed [DATA_W-1:0] right_entry,
   input  logic                     seen_in,
   output logic                     seen_out,
   output logic signed [DATA_W-1:0] entry
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   logic                     occupied;
   logic                     match;
   logic                     hit;
   logic                     has_right;

   // slot position relative to the current fill
   assign occupied  = CNT_W'(INDEX) < count;
   assign has_right = (CNT_W'(INDEX) + CNT_W'(1)) < count;

   // first-match chain from the head
   assign match    = occupied && (entry_ff == ctl.value);
   assign hit      = match && !seen_in;
   assign seen_out = seen_in || match;

   // next entry per operation
   always_comb begin
      entry_in = entry_ff;
      if (ctl.fire) begin
         case (ctl.op)
            OP_APPEND: begin
               if (CNT_W'(INDEX) == count) entry_in = ctl.value;
            end
            OP_UPDATE: begin
               if (hit) entry_in = ctl.new_value;
            end
            OP_DELETE: begin
               if (seen_out && has_right) entry_in = right_entry;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   // entry storage, no reset: only slots below the fill are read
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[rtl/core/ovl_checker.sv]
// port checker of the ordered value list engine and its bind
module ovl_checker
   import ovl_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input status_type       rsp_status,
   input logic [OCC_W-1:0] rsp_occupancy
);

   // no response word right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a match is only reported with status ok
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found set with a failing status");

   // full only when every slot is held, empty only with nothing held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_occupancy == OCC_W'(DEPTH)))
      else $error("full status with free slots");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with slots held");

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_status) && $stable(rsp_occupancy)))
      else $error("stalled response changed");

endmodule

bind ordered_value_list_engine ovl_checker #(
   .DEPTH(DEPTH)
) u_ovl_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_found    (rsp_chan.found),
   .rsp_status   (rsp_chan.status),
   .rsp_occupancy(rsp_chan.occupancy)
);

[test/ordered_value_list_engine_checker.sv]
// response checker with its own list predictor for the ordered value list engine
module ordered_value_list_engine_checker
   import ovl_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ovl_req_if          req_chan,
   ovl_rsp_if          rsp_chan,
   output int unsigned mismatches,
   output int unsigned pending
);

   typedef struct packed {
      logic             found;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } outcome_type;

   // predicted list contents, oldest first
   logic signed [DATA_W-1:0] held [DEPTH];
   int unsigned              held_count = 0;
   outcome_type              expected_q [$];

   // apply one request word to the predicted list and return its response
   function automatic outcome_type apply_request(op_type op,
                                                 logic signed [DATA_W-1:0] word_value,
                                                 logic signed [DATA_W-1:0] replacement);
      outcome_type res;
      int unsigned hit;
      res.found  = 1'b0;
      res.status = ST_OK;
      hit = held_count;
      // first match counted from the head
      for (int unsigned i = 0; i < held_count && hit == held_count; i++) begin
         if (held[i] == word_value) hit = i;
      end
      case (op)
         OP_APPEND: begin
            if (held_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held[held_count] = word_value;
               held_count++;
            end
         end
         OP_SEARCH, OP_UPDATE: begin
            if (hit < held_count) begin
               res.found = 1'b1;
               if (op == OP_UPDATE) held[hit] = replacement;
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         OP_DELETE: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else if (hit < held_count) begin
               res.found = 1'b1;
               // close the gap so later entries keep their order
               for (int unsigned i = hit; i + 1 < held_count; i++) held[i] = held[i + 1];
               held_count--;
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_W'(held_count);
      return res;
   endfunction

   task automatic note_mismatch(string what);
      if (mismatches < 10) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // responses are retired before the request of the same edge is predicted
   always @(posedge clock) begin
      outcome_type exp;
      if (reset) begin
         held_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               note_mismatch($sformatf("response word with no request outstanding: found=%0d status=%0d occupancy=%0d",
                                       rsp_chan.found, rsp_chan.status, rsp_chan.occupancy));
            end else begin
               exp = expected_q.pop_front();
               if (rsp_chan.found !== exp.found || rsp_chan.status !== exp.status ||
                   rsp_chan.occupancy !== exp.occupancy) begin
                  note_mismatch($sformatf("expected found=%0d status=%0d occupancy=%0d, got found=%0d status=%0d occupancy=%0d",
                                          exp.found, exp.status, exp.occupancy,
                                          rsp_chan.found, rsp_chan.status, rsp_chan.occupancy));
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_q.push_back(apply_request(req_chan.operation, req_chan.value,
                                               req_chan.new_value));
         end
      end
      pending = expected_q.size();
   end

endmodule

[test/ordered_value_list_engine_test.sv]
// stimulus, flow control and verdict for the ordered value list engine
module ordered_value_list_engine_test;
   import ovl_pkg::*;

   localparam int unsigned LIST_DEPTH   = 16;
   localparam int unsigned PHASES       = 16;
   localparam int unsigned PHASE_WORDS  = 100;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned POOL_SIZE    = 8;
   localparam int unsigned HISTORY_SIZE = 24;
   localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_kind_type;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatches;
   int unsigned pending;

   ovl_req_if req_chan ();
   ovl_rsp_if rsp_chan ();

   ordered_value_list_engine #(.DEPTH(LIST_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ordered_value_list_engine_checker #(.DEPTH(LIST_DEPTH)) response_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   bit                       sender_steady   = 1'b0;
   bit                       receiver_steady = 1'b0;
   int unsigned              stall_left      = 0;
   int unsigned              receiver_cycles = 0;
   int unsigned              idle_cycles     = 0;
   logic signed [DATA_W-1:0] pool [POOL_SIZE];
   logic signed [DATA_W-1:0] written_q [$];

   // idle length: mostly none or short, now and then long
   function automatic int unsigned gap_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // fresh value: pool for duplicates, extremes, or any bit pattern
   function automatic logic signed [DATA_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 70) begin
         case ($urandom_range(0, 3))
            0:       return MOST_POS;
            1:       return MOST_NEG;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // lookup value: mostly something recently written so it tends to match
   function automatic logic signed [DATA_W-1:0] target_value();
      if (written_q.size() > 0 && $urandom_range(0, 99) < 85)
         return written_q[$urandom_range(0, written_q.size() - 1)];
      return pick_value();
   endfunction

   // present one request word and hold it until it is taken
   task automatic issue_request(op_type op, logic signed [DATA_W-1:0] word_value,
                                logic signed [DATA_W-1:0] replacement);
      int unsigned gap;
      gap = sender_steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.value     <= word_value;
      req_chan.new_value <= replacement;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (op == OP_APPEND || op == OP_UPDATE)
         written_q.push_back(op == OP_APPEND ? word_value : replacement);
      if (written_q.size() > HISTORY_SIZE) void'(written_q.pop_front());
   endtask

   // hold off until every response word has come back
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // response side back pressure, with stretches of none
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         receiver_cycles++;
         if (receiver_cycles % 256 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
         if (stall_left == 0 && !receiver_steady && $urandom_range(0, 3) == 0)
            stall_left = gap_cycles();
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any word moving
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("** ordered_value_list_engine: FAILED **");
         $finish;
      end
   end

   initial begin
      phase_kind_type kind;
      int unsigned    r;
      op_type         op;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_APPEND;
      req_chan.value     <= '0;
      req_chan.new_value <= '0;
      foreach (pool[i]) pool[i] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty list: delete reports empty, search and update report not found
      issue_request(OP_DELETE, 5, 0);
      issue_request(OP_SEARCH, 5, 0);
      issue_request(OP_UPDATE, 5, 6);
      // extremes and a duplicate
      issue_request(OP_APPEND, MOST_POS, 0);
      issue_request(OP_APPEND, MOST_NEG, 0);
      issue_request(OP_APPEND, 0, 0);
      issue_request(OP_APPEND, -1, 0);
      issue_request(OP_APPEND, MOST_POS, 0);
      issue_request(OP_SEARCH, MOST_NEG, 0);
      // only the first of the duplicates is replaced
      issue_request(OP_UPDATE, MOST_POS, MOST_NEG);
      issue_request(OP_SEARCH, MOST_POS, 0);
      // delete at the head, in the middle and at the tail
      issue_request(OP_DELETE, MOST_NEG, 0);
      issue_request(OP_DELETE, 0, 0);
      issue_request(OP_DELETE, MOST_POS, 0);
      // tail must follow the deletion of the last entry
      issue_request(OP_APPEND, 7, 0);
      issue_request(OP_SEARCH, MOST_POS, 0);
      issue_request(OP_SEARCH, 7, 0);
      issue_request(OP_DELETE, 12345, 0);
      issue_request(OP_UPDATE, -1, MOST_POS);
      issue_request(OP_DELETE, MOST_NEG, 0);
      issue_request(OP_DELETE, MOST_POS, 0);
      issue_request(OP_DELETE, 7, 0);
      issue_request(OP_DELETE, 7, 0);
      wait_until_drained();

      // random phases that fill, drain and churn the list
      for (int unsigned p = 0; p < PHASES; p++) begin
         kind = phase_kind_type'(p % 3);
         sender_steady = ($urandom_range(0, 3) == 0);
         repeat (3) pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         repeat (PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            case (kind)
               FILL_PHASE:  op = r < 65 ? OP_APPEND : r < 75 ? OP_SEARCH :
                                 r < 85 ? OP_UPDATE : OP_DELETE;
               DRAIN_PHASE: op = r < 15 ? OP_APPEND : r < 30 ? OP_SEARCH :
                                 r < 45 ? OP_UPDATE : OP_DELETE;
               default:     op = r < 30 ? OP_APPEND : r < 55 ? OP_SEARCH :
                                 r < 75 ? OP_UPDATE : OP_DELETE;
            endcase
            issue_request(op, op == OP_APPEND ? pick_value() : target_value(), pick_value());
         end
         wait_until_drained();
      end

      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("** ordered_value_list_engine: PASSED **");
      end else begin
         $display("** ordered_value_list_engine: FAILED **");
      end
      $finish;
   end

endmodule
